@@ sv/hsfr_pkg.sv @@
// shared types and constants of the header sync frame receiver
package hsfr_pkg;

    // field widths fixed by the request format
    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int RIDX_W    = 5;
    localparam int ST_W      = 2;
    localparam int RUN_W     = 4;
    localparam int TICK_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CKS_W     = 16;

    // request commands
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // reception status codes
    localparam logic [ST_W-1:0] ST_NONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_OK      = 2'd1;
    localparam logic [ST_W-1:0] ST_BADSUM  = 2'd2;
    localparam logic [ST_W-1:0] ST_TIMEOUT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_CHAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_ENABLE = 2'd3;

    // configuration reset values
    localparam logic [BYTE_W-1:0] HDR_CHAR_RST  = 8'd35;
    localparam logic [RUN_W-1:0]  HDR_COUNT_RST = 4'd5;

    // configuration register set
    typedef struct packed {
        logic [BYTE_W-1:0] hdr_char;
        logic [RUN_W-1:0]  hdr_count;
        logic [TICK_W-1:0] to_limit;
        logic              to_enable;
    } t_cfg;

    // classified request passed from front to back
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data;
        logic              is_hdr;
        logic              rd_ok;
        logic [RIDX_W-1:0] rd_idx;
    } t_op;

endpackage

@@ sv/hsfr_in_if.sv @@
// request channel: command, received byte and read position
interface hsfr_in_if
    import hsfr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic [RIDX_W-1:0] read_index;

    modport source (output valid, output cmd, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input cmd, input rx_byte, input read_index,
                    output ready);
endinterface

@@ sv/hsfr_out_if.sv @@
// result channel: status, sync flag, frame completion and read data
interface hsfr_out_if
    import hsfr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic              synced;
    logic              frame_done;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, output status, output synced, output frame_done,
                    output read_data, input ready);
    modport sink   (input valid, input status, input synced, input frame_done,
                    input read_data, output ready);
endinterface

@@ sv/hsfr_ram.sv @@
// generic single write port ram with registered read
module hsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 19
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/hsfr_front.sv @@
// front end: configuration registers, request acceptance and classification
module hsfr_front
    import hsfr_pkg::*;
#(
    parameter int FRAME_LEN = 19
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    hsfr_in_if.sink              i_in,
    input  logic                 i_full,
    output logic                 o_push,
    output t_op                  o_op,
    output t_cfg                 o_cfg
);
    t_cfg r_cfg;
    t_cfg n_cfg;

    // configuration writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HDR_CHAR:  n_cfg.hdr_char  = i_cfg_data;
                CFG_HDR_COUNT: n_cfg.hdr_count = i_cfg_data[RUN_W-1:0];
                CFG_TO_LIMIT:  n_cfg.to_limit  = i_cfg_data[TICK_W-1:0];
                CFG_TO_ENABLE: n_cfg.to_enable = i_cfg_data[0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_char  <= HDR_CHAR_RST;
            r_cfg.hdr_count <= HDR_COUNT_RST;
            r_cfg.to_limit  <= TICK_W'(FRAME_LEN + 2);
            r_cfg.to_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // accept while the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // classify the request
    always_comb begin
        o_op.cmd    = i_in.cmd;
        o_op.data   = i_in.rx_byte;
        o_op.is_hdr = (i_in.rx_byte == r_cfg.hdr_char);
        o_op.rd_ok  = (32'(i_in.read_index) < FRAME_LEN);
        o_op.rd_idx = i_in.read_index;
    end

    assign o_cfg = r_cfg;
endmodule

@@ sv/hsfr_queue.sv @@
// small fifo of classified requests between front and back
module hsfr_queue
    import hsfr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_buf[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_op;
        end
    end
endmodule

@@ sv/hsfr_back.sv @@
// back end: header hunting, frame storage, checksum, timer and result register
module hsfr_back
    import hsfr_pkg::*;
#(
    parameter int FRAME_LEN   = 19,
    parameter int PAYLOAD_LEN = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_op       i_op,
    output logic      o_pop,
    hsfr_out_if.source o_res
);
    localparam int AW     = $clog2(FRAME_LEN);
    localparam int SUM_W  = $clog2(255 * PAYLOAD_LEN + 1);
    localparam int CMP_W  = (SUM_W > CKS_W) ? SUM_W : CKS_W;
    localparam int PL_END = 3 + PAYLOAD_LEN;

    // frame control state
    logic [RUN_W-1:0]     r_run, n_run;
    logic                 r_sync, n_sync;
    logic [AW-1:0]        r_fill, n_fill;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [ST_W-1:0]      r_status, n_status;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic                 r_timer, n_timer;
    logic [FRAME_LEN-1:0] r_valid, n_valid;
    logic [BYTE_W-1:0]    r_cks_hi, n_cks_hi;
    logic [BYTE_W-1:0]    r_cks_lo, n_cks_lo;

    // result register
    logic                 r_out_valid, n_out_valid;
    logic [ST_W-1:0]      r_out_status, n_out_status;
    logic                 r_out_synced, n_out_synced;
    logic                 r_out_done, n_out_done;
    logic                 r_out_rd, n_out_rd;

    // store access
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [BYTE_W-1:0]    ram_rdata;
    logic                 fire;

    assign fire  = i_valid && (!r_out_valid || o_res.ready);
    assign o_pop = fire;
    assign ram_raddr = AW'(i_op.rd_idx);

    // execute one request
    always_comb begin
        logic             sync_now;
        logic [AW-1:0]    idx;
        logic [RUN_W-1:0] run_inc;
        logic [SUM_W-1:0] sum_base;
        logic [SUM_W-1:0] sum_new;
        logic [TICK_W-1:0] tick_inc;
        logic             done;
        logic             rd_sel;

        n_run    = r_run;
        n_sync   = r_sync;
        n_fill   = r_fill;
        n_sum    = r_sum;
        n_status = r_status;
        n_tick   = r_tick;
        n_timer  = r_timer;
        n_valid  = r_valid;
        n_cks_hi = r_cks_hi;
        n_cks_lo = r_cks_lo;
        ram_we    = 1'b0;
        ram_waddr = r_fill;
        ram_re    = 1'b0;
        sync_now  = r_sync;
        idx       = r_fill;
        run_inc   = r_run + 1'b1;
        sum_base  = r_sum;
        sum_new   = r_sum;
        tick_inc  = r_tick + 1'b1;
        done      = 1'b0;
        rd_sel    = 1'b0;

        if (fire) begin
            case (i_op.cmd)
                CMD_BYTE: begin
                    // header hunting
                    if (i_op.is_hdr && !r_sync) begin
                        n_run = run_inc;
                        if (run_inc == i_cfg.hdr_count) begin
                            sync_now = 1'b1;
                            n_sync   = 1'b1;
                            idx      = '0;
                            n_run    = '0;
                            n_tick   = '0;
                            n_timer  = 1'b1;
                        end
                    end else begin
                        n_run = '0;
                    end

                    if (!sync_now) begin
                        n_status = ST_NONE;
                    end else begin
                        // store byte and keep the running payload sum
                        ram_we     = 1'b1;
                        ram_waddr  = idx;
                        n_valid[idx] = 1'b1;
                        sum_base   = (idx == '0) ? '0 : r_sum;
                        if (32'(idx) >= 3 && 32'(idx) < PL_END) begin
                            sum_new = sum_base + SUM_W'(i_op.data);
                        end else begin
                            sum_new = sum_base;
                        end
                        n_sum = sum_new;
                        if (idx == AW'(1)) begin
                            n_cks_hi = i_op.data;
                        end
                        if (idx == AW'(2)) begin
                            n_cks_lo = i_op.data;
                        end
                        // last position closes the frame
                        if (idx == AW'(FRAME_LEN - 1)) begin
                            done   = 1'b1;
                            n_fill = '0;
                            if (r_status != ST_TIMEOUT) begin
                                n_timer  = 1'b0;
                                n_tick   = '0;
                                n_status = (CMP_W'({r_cks_hi, r_cks_lo}) == CMP_W'(sum_new))
                                           ? ST_OK : ST_BADSUM;
                            end
                        end else begin
                            n_fill = idx + 1'b1;
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_timer && i_cfg.to_enable) begin
                        n_tick = tick_inc;
                        if (tick_inc == i_cfg.to_limit) begin
                            n_status = ST_TIMEOUT;
                            n_timer  = 1'b0;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_run    = '0;
                    n_sync   = 1'b0;
                    n_fill   = '0;
                    n_sum    = '0;
                    n_status = ST_NONE;
                    n_tick   = '0;
                    n_timer  = 1'b0;
                    n_valid  = '0;
                end
                CMD_READ: begin
                    ram_re = 1'b1;
                    rd_sel = i_op.rd_ok && r_valid[ram_raddr];
                end
                default: begin
                    n_status = r_status;
                end
            endcase
        end

        // result register follows each executed request
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_synced = r_out_synced;
        n_out_done   = r_out_done;
        n_out_rd     = r_out_rd;
        if (fire) begin
            n_out_valid  = 1'b1;
            n_out_status = n_status;
            n_out_synced = n_sync;
            n_out_done   = done;
            n_out_rd     = rd_sel;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_sync      <= 1'b0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_status    <= ST_NONE;
            r_tick      <= '0;
            r_timer     <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_run       <= n_run;
            r_sync      <= n_sync;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_status    <= n_status;
            r_tick      <= n_tick;
            r_timer     <= n_timer;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cks_hi     <= n_cks_hi;
        r_cks_lo     <= n_cks_lo;
        r_out_status <= n_out_status;
        r_out_synced <= n_out_synced;
        r_out_done   <= n_out_done;
        r_out_rd     <= n_out_rd;
    end

    // frame store
    hsfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_op.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result channel
    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.synced     = r_out_synced;
    assign o_res.frame_done = r_out_done;
    assign o_res.read_data  = r_out_rd ? ram_rdata : '0;
endmodule

@@ sv/header_sync_frame_receiver_unit.sv @@
// top level of the header sync frame receiver
//
// requests arrive on i_in (valid/ready): cmd 0 carries a received byte,
// cmd 1 a bit-period tick, cmd 2 clears the frame, cmd 3 reads a stored
// byte at read_index. every request gives exactly one result on o_res
// (valid/ready) with status, sync flag, frame completion and read data.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// no request is in flight: header char, header count, timeout limit and
// timeout enable.
// a request passes through the queue and then the result register before
// its result is presented on o_res; one request is taken per cycle while
// o_res takes results, limited by the state update in the back end. a
// two-entry queue separates acceptance from execution and a result register
// holds the finished result, so i_in keeps accepting while the result waits
// until the queue fills. a stalled o_res holds its result.
// synchronous reset clears the frame state, the queue and the result valid
// flag; the frame store reads as zero until written again.
module header_sync_frame_receiver_unit
    import hsfr_pkg::*;
#(
    parameter int FRAME_LEN   = 19,
    parameter int PAYLOAD_LEN = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    hsfr_in_if.sink              i_in,
    hsfr_out_if.source           o_res
);
    t_cfg cfg;
    t_op  front_op;
    t_op  queue_op;
    logic push;
    logic full;
    logic queue_valid;
    logic pop;

    // acceptance and classification
    hsfr_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_op       (front_op),
        .o_cfg      (cfg)
    );

    // decoupling queue
    hsfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (full),
        .o_valid (queue_valid),
        .o_op    (queue_op),
        .i_pop   (pop)
    );

    // execution and result
    hsfr_back #(
        .FRAME_LEN   (FRAME_LEN),
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (queue_valid),
        .i_op    (queue_op),
        .o_pop   (pop),
        .o_res   (o_res)
    );
endmodule
